// ===== src/mlth_pkg.sv =====
// Shared constants, types and helpers of the multi-level tagged hash table.
package mlth_pkg;

    localparam int LINE_SLOTS        = 8;
    localparam int FIRST_LEVEL_SLOTS = 1024;
    localparam int MAX_LEVELS        = 4;
    localparam int MAX_PROBES        = 4;

    localparam int TOTAL_SLOTS = FIRST_LEVEL_SLOTS * ((1 << MAX_LEVELS) - 1);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
    localparam int LINE_W      = $clog2(LINE_SLOTS);
    localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
    localparam int LVL_IDX_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PROBE_W     = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int NPROBE_W    = $clog2(MAX_PROBES + 1);
    localparam int FIRST_LINES = FIRST_LEVEL_SLOTS / LINE_SLOTS;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [2:0] CFG_PROBE_COUNT = 3'd0;
    localparam logic [2:0] CFG_SEED_ZERO   = 3'd1;
    localparam logic [2:0] CFG_SEED_ONE    = 3'd2;
    localparam logic [2:0] CFG_SEED_TWO    = 3'd3;
    localparam logic [2:0] CFG_SEED_THREE  = 3'd4;

    localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2 = 32'h1b873593;
    localparam logic [31:0] MUR_C3 = 32'h85ebca6b;
    localparam logic [31:0] MUR_C4 = 32'hc2b2ae35;
    localparam logic [31:0] MUR_E  = 32'he6546b64;

    // Slot mark layout: occupied, deleted, then the 8-bit tag.
    localparam logic [9:0] MARK_OCC = 10'h200;
    localparam logic [9:0] MARK_DEL = 10'h100;

    typedef struct packed {
        logic [2:0]       probe_count;
        logic [3:0][31:0] seeds;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                  func;
        logic [63:0]                 key;
        logic [7:0]                  tag;
        logic [NPROBE_W-1:0]         nprobe;
        logic [MAX_PROBES-1:0][31:0] hashes;
    } t_job;

    function automatic logic [ADDR_W-1:0] lvl_base(input logic [LVL_IDX_W-1:0] lvl);
        logic [31:0] b;
        b = 32'(FIRST_LEVEL_SLOTS) * ((32'd1 << lvl) - 32'd1);
        return b[ADDR_W-1:0];
    endfunction

    function automatic logic [31:0] lvl_mask(input logic [LVL_IDX_W-1:0] lvl);
        return (32'(FIRST_LINES) << lvl) - 32'd1;
    endfunction

endpackage

// ===== src/mlth_front.sv =====
// Front end: takes an operation, forms its tag and seeded hashes.
module mlth_front
    import mlth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_item_key,
    input  t_cfg        i_cfg,
    output logic        o_busy,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_ready
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_K2   = 3'd1;
    localparam logic [2:0] F_H1   = 3'd2;
    localparam logic [2:0] F_H2   = 3'd3;
    localparam logic [2:0] F_H3   = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    logic [2:0]         r_state;
    logic [PROBE_W-1:0] r_p;
    logic [31:0]        r_k;
    logic [31:0]        r_h;
    t_job               r_job;

    logic [31:0]         in_low;
    logic [NPROBE_W-1:0] np_in;
    logic [31:0]         k_rot;
    logic [31:0]         hx;
    logic [31:0]         hr;
    logic [31:0]         hm;
    logic [31:0]         hm2;
    logic [31:0]         h2;
    logic                accept;

    assign in_low = i_item_key[31:0];
    assign accept = i_push && (r_state == F_IDLE);
    assign o_busy = (r_state != F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job = r_job;

    always_comb begin
        if (i_cfg.probe_count == 3'd0) begin
            np_in = NPROBE_W'(1);
        end else if (32'(i_cfg.probe_count) > 32'(MAX_PROBES)) begin
            np_in = NPROBE_W'(MAX_PROBES);
        end else begin
            np_in = NPROBE_W'(i_cfg.probe_count);
        end
    end

    always_comb begin
        k_rot = {r_k[16:0], r_k[31:17]};
        hx    = i_cfg.seeds[2'(r_p)] ^ r_k;
        hr    = {hx[18:0], hx[31:19]};
        hm    = ((hr << 2) + hr + MUR_E) ^ 32'd4;
        hm2   = hm ^ (hm >> 16);
        h2    = r_h ^ (r_h >> 13);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_p     <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_K2;
                    end
                end
                F_K2:   r_state <= F_H1;
                F_H1:   r_state <= F_H2;
                F_H2:   r_state <= F_H3;
                F_H3: begin
                    if (NPROBE_W'(r_p) == r_job.nprobe - NPROBE_W'(1)) begin
                        r_state <= F_PUSH;
                        r_p     <= '0;
                    end else begin
                        r_state <= F_H1;
                        r_p     <= r_p + PROBE_W'(1);
                    end
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_job.func   <= i_func;
                r_job.key    <= i_item_key;
                r_job.tag    <= in_low[7:0] ^ in_low[15:8] ^ in_low[23:16] ^ in_low[31:24];
                r_job.nprobe <= np_in;
                r_k          <= 32'(in_low * MUR_C1);
            end
            F_K2: r_k <= 32'(k_rot * MUR_C2);
            F_H1: r_h <= 32'(hm2 * MUR_C3);
            F_H2: r_h <= 32'(h2 * MUR_C4);
            F_H3: r_job.hashes[r_p] <= r_h ^ (r_h >> 16);
            default: ;
        endcase
    end

endmodule

// ===== src/mlth_queue.sv =====
// Two-entry queue that parts the hashing front end from the table walker.
module mlth_queue
    import mlth_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_data,
    output logic o_ready,
    output logic o_valid,
    output t_job o_data,
    input  logic i_rd
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       do_wr;
    logic       do_rd;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_wr   = i_wr && o_ready;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wp <= ~r_wp;
            end
            if (do_rd) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/mlth_back.sv =====
// Back end: walks levels, probes and line slots in the slot memories and stores the result.
module mlth_back
    import mlth_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_take,
    output logic       o_empty,
    input  logic       i_pop,
    output logic       o_success,
    output logic       o_table_full,
    output logic [2:0] o_levels_used
);

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_READ  = 3'd2;
    localparam logic [2:0] B_EVAL  = 3'd3;
    localparam logic [2:0] B_FIN   = 3'd4;

    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_EMPTY = 2'd1;
    localparam logic [1:0] HIT_LIVE  = 2'd2;
    localparam logic [1:0] HIT_DEAD  = 2'd3;

    logic [9:0]  r_marks [TOTAL_SLOTS];
    logic [63:0] r_keys  [TOTAL_SLOTS];

    logic [2:0]         r_state;
    logic [ADDR_W-1:0]  r_clr;
    t_job               r_job;
    logic [LVL_W-1:0]   r_lvl;
    logic [PROBE_W-1:0] r_p;
    logic [LINE_W-1:0]  r_i;
    logic               r_ext;
    logic [1:0]         r_hit;
    logic [ADDR_W-1:0]  r_addr;
    logic [LVL_W-1:0]   r_active;
    logic [9:0]         r_mark_q;
    logic [63:0]        r_key_q;
    logic               r_out_valid;
    logic               r_out_success;
    logic               r_out_full;
    logic [2:0]         r_out_levels;

    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       line_sel;
    logic [LINE_W-1:0] slot_sel;
    logic              mark_we;
    logic [ADDR_W-1:0] mark_wa;
    logic [9:0]        mark_wd;
    logic              key_we;
    logic              out_free;
    logic              last_i;
    logic              last_p;
    logic              last_l;
    logic              is_ins;
    logic              fin_full;
    logic              fin_success;

    assign o_empty       = ~r_out_valid;
    assign o_success     = r_out_success;
    assign o_table_full  = r_out_full;
    assign o_levels_used = r_out_levels;
    assign o_job_take    = (r_state == B_IDLE) && i_job_valid;
    assign out_free      = ~r_out_valid || i_pop;
    assign is_ins        = (r_job.func == FUNC_INSERT);

    // Slot address: level base, then the hashed line, then the tag-rotated slot.
    always_comb begin
        line_sel = (r_job.hashes[r_p] & lvl_mask(r_lvl[LVL_IDX_W-1:0])) << LINE_W;
        slot_sel = r_job.tag[LINE_W-1:0] + r_i;
        rd_addr  = lvl_base(r_lvl[LVL_IDX_W-1:0]) + line_sel[ADDR_W-1:0]
                 + ADDR_W'(slot_sel);
    end

    always_comb begin
        last_i = (r_i == LINE_W'(LINE_SLOTS - 1));
        last_p = (NPROBE_W'(r_p) == r_job.nprobe - NPROBE_W'(1));
        last_l = r_ext || (r_lvl + LVL_W'(1) >= r_active);
    end

    always_comb begin
        fin_success = 1'b0;
        case (r_job.func)
            FUNC_INSERT: fin_success = (r_hit == HIT_EMPTY) || (r_hit == HIT_DEAD);
            FUNC_DELETE,
            FUNC_QUERY:  fin_success = (r_hit == HIT_LIVE);
            default:     fin_success = 1'b0;
        endcase
        fin_full = is_ins && (r_hit == HIT_NONE) && !r_ext;
    end

    always_comb begin
        mark_we = 1'b0;
        mark_wa = r_addr;
        mark_wd = MARK_OCC | {2'b00, r_job.tag};
        key_we  = 1'b0;
        if (r_state == B_CLEAR) begin
            mark_we = 1'b1;
            mark_wa = r_clr;
            mark_wd = '0;
        end else if (r_state == B_FIN && out_free && fin_success) begin
            if (is_ins) begin
                mark_we = 1'b1;
                key_we  = 1'b1;
            end else if (r_job.func == FUNC_DELETE) begin
                mark_we = 1'b1;
                mark_wd = r_mark_q | MARK_DEL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_marks[mark_wa] <= mark_wd;
        end
        if (r_state == B_READ) begin
            r_mark_q <= r_marks[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_keys[r_addr] <= r_job.key;
        end
        if (r_state == B_READ) begin
            r_key_q <= r_keys[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_active    <= LVL_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(TOTAL_SLOTS - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= (i_job.func == FUNC_INSERT || i_job.func == FUNC_DELETE
                                    || i_job.func == FUNC_QUERY) ? B_READ : B_FIN;
                    end
                end
                B_READ: r_state <= B_EVAL;
                B_EVAL: begin
                    if (!r_mark_q[9] || (r_mark_q[7:0] == r_job.tag && r_key_q == r_job.key)) begin
                        r_state <= B_FIN;
                    end else if (last_i && last_p && last_l) begin
                        r_state <= (is_ins && !r_ext && r_active < LVL_W'(MAX_LEVELS))
                                 ? B_READ : B_FIN;
                    end else begin
                        r_state <= B_READ;
                    end
                end
                B_FIN: begin
                    if (out_free) begin
                        r_state       <= B_IDLE;
                        r_out_valid   <= 1'b1;
                        r_active      <= r_active + LVL_W'(r_ext);
                        r_out_levels  <= 3'(r_active + LVL_W'(r_ext));
                        r_out_success <= fin_success;
                        r_out_full    <= fin_full;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Walk counters and the hit record.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
                r_lvl <= '0;
                r_p   <= '0;
                r_i   <= '0;
                r_ext <= 1'b0;
                r_hit <= HIT_NONE;
            end
            B_READ: r_addr <= rd_addr;
            B_EVAL: begin
                if (!r_mark_q[9]) begin
                    r_hit <= HIT_EMPTY;
                end else if (r_mark_q[7:0] == r_job.tag && r_key_q == r_job.key) begin
                    r_hit <= r_mark_q[8] ? HIT_DEAD : HIT_LIVE;
                end else if (!last_i) begin
                    r_i <= r_i + LINE_W'(1);
                end else if (!last_p) begin
                    r_i <= '0;
                    r_p <= r_p + PROBE_W'(1);
                end else if (!last_l) begin
                    r_i   <= '0;
                    r_p   <= '0;
                    r_lvl <= r_lvl + LVL_W'(1);
                end else if (is_ins && !r_ext && r_active < LVL_W'(MAX_LEVELS)) begin
                    // Every level missed: open the next one and probe it.
                    r_i   <= '0;
                    r_p   <= '0;
                    r_lvl <= r_active;
                    r_ext <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active >= LVL_W'(1) && r_active <= LVL_W'(MAX_LEVELS))
        else $error("active level count out of range");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !r_out_valid)
        else $error("result produced during clearing pass");

    a_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_full) |-> (!r_out_success && r_out_levels == 3'(MAX_LEVELS)))
        else $error("full result with success or spare levels");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_READ) |-> (r_lvl < LVL_W'(MAX_LEVELS)))
        else $error("probe beyond the last level");

endmodule

// ===== src/multi_level_tagged_hash_table.sv =====
// Top level of the multi-level tagged hash table: configuration registers and block wiring.
// Operations (insert, delete, query) enter through a queue-style port and each gives one result.
// After reset the block clears all 15360 slot marks, one slot a cycle. The first operations
// are still taken and hashed meanwhile. Full is high while the hashing stage is busy, also
// while it waits for room in the queue behind it. Full is held high and the configuration
// ready low while reset is asserted; configuration writes are taken at any other time.
// Hashing forms the tag and then one seeded 32-bit hash per probe. The table walk does one
// registered memory read and then one compare per slot visited, from a hit in the first
// slot up to levels * probes * 8 slots for a full miss, with one more slot when an insert
// opens a new level; an idle state takes the job and a finish state stores the result.
// A two-entry queue lets hashing of the next operation overlap the walk of the current one.
module multi_level_tagged_hash_table
    import mlth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_item_key,
    output logic        empty,
    input  logic        pop,
    output logic        o_success,
    output logic        o_table_full,
    output logic [2:0]  o_levels_used,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    logic front_busy;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_take;

    assign o_cfg_ready = i_rst_n;
    assign full        = front_busy || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.probe_count <= 3'd2;
            r_cfg.seeds[0]    <= 32'd1;
            r_cfg.seeds[1]    <= 32'd2;
            r_cfg.seeds[2]    <= 32'd3;
            r_cfg.seeds[3]    <= 32'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROBE_COUNT: r_cfg.probe_count <= i_cfg_data[2:0];
                CFG_SEED_ZERO:   r_cfg.seeds[0]    <= i_cfg_data;
                CFG_SEED_ONE:    r_cfg.seeds[1]    <= i_cfg_data;
                CFG_SEED_TWO:    r_cfg.seeds[2]    <= i_cfg_data;
                CFG_SEED_THREE:  r_cfg.seeds[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlth_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_func      (i_func),
        .i_item_key  (i_item_key),
        .i_cfg       (r_cfg),
        .o_busy      (front_busy),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (queue_ready)
    );

    mlth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_data  (front_job),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_job),
        .i_rd    (back_take)
    );

    mlth_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (queue_valid),
        .i_job         (queue_job),
        .o_job_take    (back_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_success     (o_success),
        .o_table_full  (o_table_full),
        .o_levels_used (o_levels_used)
    );

endmodule
